[design/utf8_text_glyph_row_generator_assert.svh]
// ---------------------------------------------------------------------------
// utf8 text glyph row generator assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef UTF8_TEXT_GLYPH_ROW_GENERATOR_ASSERT_SVH
`define UTF8_TEXT_GLYPH_ROW_GENERATOR_ASSERT_SVH

// same-cycle implication under reset
`define U8G_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define U8G_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/u8g_pkg.sv]
// ---------------------------------------------------------------------------
// u8g_pkg
// constants, codes and types of the utf8 text glyph row generator
// ---------------------------------------------------------------------------
package u8g_pkg;

    localparam int GLYPHS   = 256;
    localparam int ROWS     = 16;
    localparam int COLS     = 8;

    localparam int DEPTH    = GLYPHS * ROWS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int GLYPH_W  = $clog2(GLYPHS);
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CP_W     = 21;
    localparam int BIT_W    = 16;
    localparam int POS_W    = 16;
    localparam int COLOR_W  = 32;
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 112;

    localparam logic [7:0] ONE_BYTE_MAX   = 8'h7F;
    localparam logic [7:0] TWO_BYTE_MAX   = 8'hDF;
    localparam logic [7:0] THREE_BYTE_MAX = 8'hEF;
    localparam logic [7:0] LEAD2_MASK     = 8'h1F;
    localparam logic [7:0] LEAD3_MASK     = 8'h0F;
    localparam logic [7:0] LEAD4_MASK     = 8'h07;
    localparam logic [7:0] CONT_MASK      = 8'h3F;
    localparam int         BIT_MSB        = 15;

    localparam logic [BIT_W-1:0] COL_MASK = ~(16'hFFFF >> COLS);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TEXT  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EMIT,
        ST_ADV
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BIT_W-1:0]  data;
    } store_wr_t;

endpackage

[design/u8g_store.sv]
// ---------------------------------------------------------------------------
// u8g_store
// glyph row store, one write port and one registered read port
// ---------------------------------------------------------------------------
module u8g_store
    import u8g_pkg::*;
(
    input  logic              clk,
    input  store_wr_t         wr,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BIT_W-1:0]  rd_data
);

    logic [BIT_W-1:0] store_mem [DEPTH];
    logic [BIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/utf8_text_glyph_row_generator.sv]
// ---------------------------------------------------------------------------
// utf8_text_glyph_row_generator
// character generator: utf8 text in, bitmap glyph rows out
//
// input words carry a command in s_axis_tuser: load writes one glyph row into
// the store, start sets pen position and colors and clears the decoder, text
// feeds one utf8 byte. each completed code point gives ROWS output words, one
// per glyph row, with the last one marked by m_axis_tlast and code points past
// the store flagged in m_axis_tuser.
// load, start and incomplete text words leave the generator idle. a completing
// text word issues one row per cycle from the single store read port, unless the
// receiver stalls, then the shared adder advances the pen in ST_ADV.
// s_axis_tready stays low while rows are issued. the output register lets the
// next word in while the final row still waits; a stalled receiver holds row
// issue at the current row.
// after reset the store is swept to zero, one entry per cycle, with
// s_axis_tready low.
// ---------------------------------------------------------------------------
module utf8_text_glyph_row_generator
    import u8g_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // text_byte, start_x, start_y, back_color, fore_color, load_code,
    // load_row, load_bits, zero pad
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // command
    input  logic [1:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // cell_x, pixel_y, pixel_bits, back_out, fore_out
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // glyph_missing
    output logic                m_axis_tuser,
    // last_row
    output logic                m_axis_tlast
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [CP_W-1:0]     code_accum_reg, code_accum_next;
    logic [1:0]          pending_reg, pending_next;
    logic                missing_reg, missing_next;
    logic [POS_W-1:0]    pen_x_reg, pen_x_next;
    logic [POS_W-1:0]    base_y_reg, base_y_next;
    logic [COLOR_W-1:0]  back_reg, back_next;
    logic [COLOR_W-1:0]  fore_reg, fore_next;
    logic                out_valid_reg, out_valid_next;

    logic [POS_W-1:0]    cell_x_reg;
    logic [POS_W-1:0]    pixel_y_reg;
    logic [BIT_W-1:0]    pixel_bits_reg;
    logic [COLOR_W-1:0]  back_out_reg;
    logic [COLOR_W-1:0]  fore_out_reg;
    logic                missing_out_reg;
    logic                last_out_reg;

    logic                s_accept;
    logic                out_free;
    logic                out_load;
    logic                row_last;
    cmd_t                cmd;
    logic [7:0]          text_byte;
    logic [POS_W-1:0]    start_x;
    logic [POS_W-1:0]    start_y;
    logic [COLOR_W-1:0]  back_color;
    logic [COLOR_W-1:0]  fore_color;
    logic [7:0]          load_code;
    logic [3:0]          load_row;
    logic [BIT_W-1:0]    load_bits;
    logic                load_ok;
    logic [CP_W-1:0]     acc_dec;
    logic [1:0]          pend_dec;
    logic [ADDR_W-1:0]   glyph_base;
    logic [ADDR_W-1:0]   load_addr;
    logic [POS_W-1:0]    add_a, add_b, add_sum;
    logic [BIT_W-1:0]    rd_data;
    logic [BIT_W-1:0]    row_bits;
    store_wr_t           store_wr;

    assign cmd        = cmd_t'(s_axis_tuser);
    assign text_byte  = s_axis_tdata[7:0];
    assign start_x    = s_axis_tdata[23:8];
    assign start_y    = s_axis_tdata[39:24];
    assign back_color = s_axis_tdata[71:40];
    assign fore_color = s_axis_tdata[103:72];
    assign load_code  = s_axis_tdata[111:104];
    assign load_row   = s_axis_tdata[115:112];
    assign load_bits  = s_axis_tdata[131:116];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_EMIT) && out_free;
    assign row_last      = (row_reg == ROW_W'(ROWS - 1));

    assign load_ok   = (32'(load_code) < GLYPHS) && (32'(load_row) < ROWS)
                       && (load_row <= 4'(BIT_MSB));
    assign load_addr = ADDR_W'(ADDR_W'(load_code) * ADDR_W'(ROWS)) + ADDR_W'(load_row);

    // utf8 byte decode, no validation
    always_comb
    begin
        acc_dec  = code_accum_reg;
        pend_dec = pending_reg;
        if (pending_reg == 2'd0)
        begin
            if (text_byte <= ONE_BYTE_MAX)
            begin
                acc_dec  = CP_W'(text_byte);
                pend_dec = 2'd0;
            end
            else if (text_byte <= TWO_BYTE_MAX)
            begin
                acc_dec  = CP_W'(text_byte & LEAD2_MASK);
                pend_dec = 2'd1;
            end
            else if (text_byte <= THREE_BYTE_MAX)
            begin
                acc_dec  = CP_W'(text_byte & LEAD3_MASK);
                pend_dec = 2'd2;
            end
            else
            begin
                acc_dec  = CP_W'(text_byte & LEAD4_MASK);
                pend_dec = 2'd3;
            end
        end
        else
        begin
            acc_dec  = {code_accum_reg[CP_W-7:0], 6'(text_byte & CONT_MASK)};
            pend_dec = pending_reg - 2'd1;
        end
    end

    assign glyph_base = ADDR_W'(ADDR_W'(acc_dec[GLYPH_W-1:0]) * ADDR_W'(ROWS));

    // shared adder: row y during issue, pen advance afterwards
    assign add_a   = (state_reg == ST_ADV) ? pen_x_reg : base_y_reg;
    assign add_b   = (state_reg == ST_ADV) ? POS_W'(COLS) : POS_W'(row_reg);
    assign add_sum = add_a + add_b + POS_W'(1);

    assign row_bits = missing_reg ? '0 : (rd_data & COL_MASK);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept && (cmd == CMD_TEXT) && (pend_dec == 2'd0))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && row_last)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        rd_addr_next    = rd_addr_reg;
        row_next        = row_reg;
        code_accum_next = code_accum_reg;
        pending_next    = pending_reg;
        missing_next    = missing_reg;
        pen_x_next      = pen_x_reg;
        base_y_next     = base_y_reg;
        back_next       = back_reg;
        fore_next       = fore_reg;
        store_wr        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                store_wr.en   = 1'b1;
                store_wr.addr = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (cmd)
                        CMD_LOAD:
                        begin
                            store_wr.en   = load_ok;
                            store_wr.addr = load_addr;
                            store_wr.data = load_bits;
                        end
                        CMD_START:
                        begin
                            pen_x_next      = start_x;
                            base_y_next     = start_y;
                            back_next       = back_color;
                            fore_next       = fore_color;
                            code_accum_next = '0;
                            pending_next    = 2'd0;
                        end
                        CMD_TEXT:
                        begin
                            code_accum_next = acc_dec;
                            pending_next    = pend_dec;
                            missing_next    = (acc_dec >= CP_W'(GLYPHS));
                            rd_addr_next    = glyph_base;
                            row_next        = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free && !row_last)
                begin
                    row_next     = row_reg + ROW_W'(1);
                    rd_addr_next = rd_addr_reg + ADDR_W'(1);
                end
            end
            ST_ADV:
            begin
                pen_x_next = add_sum;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            rd_addr_reg    <= '0;
            row_reg        <= '0;
            code_accum_reg <= '0;
            pending_reg    <= 2'd0;
            missing_reg    <= 1'b0;
            pen_x_reg      <= '0;
            base_y_reg     <= '0;
            back_reg       <= '0;
            fore_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            rd_addr_reg    <= rd_addr_next;
            row_reg        <= row_next;
            code_accum_reg <= code_accum_next;
            pending_reg    <= pending_next;
            missing_reg    <= missing_next;
            pen_x_reg      <= pen_x_next;
            base_y_reg     <= base_y_next;
            back_reg       <= back_next;
            fore_reg       <= fore_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cell_x_reg      <= pen_x_reg;
            pixel_y_reg     <= add_sum;
            pixel_bits_reg  <= row_bits;
            back_out_reg    <= back_reg;
            fore_out_reg    <= fore_reg;
            missing_out_reg <= missing_reg;
            last_out_reg    <= row_last;
        end
    end

    // the store reads rd_addr_next so its registered rd_data matches row_reg
    u8g_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_addr (rd_addr_next),
        .rd_data (rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {fore_out_reg, back_out_reg, pixel_bits_reg, pixel_y_reg, cell_x_reg};
    assign m_axis_tuser  = missing_out_reg;
    assign m_axis_tlast  = last_out_reg;

endmodule

[design/u8g_checker.sv]
// ---------------------------------------------------------------------------
// u8g_checker
// port-level checks of the utf8 text glyph row generator
// ---------------------------------------------------------------------------
`include "utf8_text_glyph_row_generator_assert.svh"

module u8g_checker
    import u8g_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [1:0]          s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata,
    input logic                m_axis_tuser,
    input logic                m_axis_tlast
);

    logic m_accept;
    logic s_busy_probe;

    assign m_accept     = m_axis_tvalid && m_axis_tready;
    assign s_busy_probe = s_axis_tvalid || (s_axis_tuser == CMD_TEXT);

    `U8G_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

    `U8G_ASSERT_IMPL(a_busy_mid_glyph, m_axis_tvalid && !m_axis_tlast && s_busy_probe,
        !s_axis_tready, "input taken while glyph rows remain")

    `U8G_ASSERT_IMPL(a_missing_blank, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[47:32] == 16'd0, "missing glyph row is not blank")

    `U8G_ASSERT_NEXT(a_row_follow, m_accept && !m_axis_tlast,
        m_axis_tvalid && (m_axis_tdata[15:0] == $past(m_axis_tdata[15:0]))
        && (m_axis_tdata[31:16] == $past(m_axis_tdata[31:16]) + 16'd1),
        "next row of a glyph out of order")

endmodule

bind utf8_text_glyph_row_generator u8g_checker u_checker (.*);

[bench/utf8_text_glyph_row_generator_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_text_glyph_row_generator_tb
// self-checking bench for the utf8 character generator
//
// loads glyph rows, starts text runs and feeds utf8 bytes through the input
// stream, with random gaps on the sender and random stalls on the receiver.
// a directed table covers the zero byte, missing glyphs, pen and row wrap,
// an unused command and a start in the middle of a sequence. random words
// follow. a local model of the glyph store, the decoder and the pen predicts
// every output word, which is checked field by field in arrival order.
// ---------------------------------------------------------------------------
module utf8_text_glyph_row_generator_tb;
    import u8g_pkg::*;

    localparam int          TXT_LSB    = 0;
    localparam int          SX_LSB     = 8;
    localparam int          SY_LSB     = 24;
    localparam int          BK_LSB     = 40;
    localparam int          FG_LSB     = 72;
    localparam int          CODE_LSB   = 104;
    localparam int          ROW_LSB    = 112;
    localparam int          BITS_LSB   = 116;
    localparam int          PAD_LSB    = 132;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          IDLE_LIMIT = 20000;
    localparam int          HOLD_LEN   = 400;
    localparam int          RAND_WORDS = 100;

    typedef struct packed {
        logic [POS_W-1:0]   cell_x;
        logic [POS_W-1:0]   pixel_y;
        logic [BIT_W-1:0]   pixel_bits;
        logic [COLOR_W-1:0] back_out;
        logic [COLOR_W-1:0] fore_out;
        logic               missing;
        logic               last;
    } glyph_row_t;

    typedef struct {
        logic [1:0]          cmd;
        logic [S_DATA_W-1:0] data;
        bit                  typed;
        logic [POS_W-1:0]    x0;
        logic [POS_W-1:0]    y0;
        logic [COLOR_W-1:0]  back;
        logic [COLOR_W-1:0]  fore;
        logic                missing;
    } stim_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;

    // model state
    logic [BIT_W-1:0]   font_mem [DEPTH];
    logic [CP_W-1:0]    cp_accum;
    logic [1:0]         cont_left;
    logic [POS_W-1:0]   pen_x;
    logic [POS_W-1:0]   base_y;
    logic [COLOR_W-1:0] back_reg;
    logic [COLOR_W-1:0] fore_reg;

    glyph_row_t row_q [$];
    int         fails = 0;
    int         words_sent;
    int         idle_cycles = 0;
    bit         hold_req;
    bit         hold_done = 1'b0;

    utf8_text_glyph_row_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic [S_DATA_W-1:0] rand_bus();
        logic [S_DATA_W-1:0] v;
        v[31:0]    = $urandom;
        v[63:32]   = $urandom;
        v[95:64]   = $urandom;
        v[127:96]  = $urandom;
        v[135:128] = 8'($urandom_range(0, 255));
        v[S_DATA_W-1:PAD_LSB] = '0;
        return v;
    endfunction

    function automatic stim_t mk_load(logic [7:0] code, logic [3:0] row, logic [15:0] bits);
        stim_t s;
        s = '{default: '0};
        s.cmd  = CMD_LOAD;
        s.data = rand_bus();
        s.data[CODE_LSB +: 8] = code;
        s.data[ROW_LSB +: 4]  = row;
        s.data[BITS_LSB +: 16] = bits;
        return s;
    endfunction

    function automatic stim_t mk_start(logic [15:0] x, logic [15:0] y,
                                       logic [31:0] back, logic [31:0] fore);
        stim_t s;
        s = '{default: '0};
        s.cmd  = CMD_START;
        s.data = rand_bus();
        s.data[SX_LSB +: 16] = x;
        s.data[SY_LSB +: 16] = y;
        s.data[BK_LSB +: 32] = back;
        s.data[FG_LSB +: 32] = fore;
        return s;
    endfunction

    function automatic stim_t mk_text(logic [7:0] b);
        stim_t s;
        s = '{default: '0};
        s.cmd  = CMD_TEXT;
        s.data = rand_bus();
        s.data[TXT_LSB +: 8] = b;
        return s;
    endfunction

    function automatic stim_t mk_unused();
        stim_t s;
        s = '{default: '0};
        s.cmd  = CMD_UNUSED;
        s.data = rand_bus();
        return s;
    endfunction

    // blank glyph with known position and colors
    function automatic stim_t with_blank(stim_t s, logic [15:0] x0, logic [15:0] y0,
                                         logic [31:0] back, logic [31:0] fore,
                                         logic missing);
        s.typed   = 1'b1;
        s.x0      = x0;
        s.y0      = y0;
        s.back    = back;
        s.fore    = fore;
        s.missing = missing;
        return s;
    endfunction

    task automatic render_glyph(input logic [CP_W-1:0] cp);
        glyph_row_t g;
        bit         absent;
        absent = (cp >= GLYPHS);
        for (int r = 0; r < ROWS; r++)
        begin
            g.cell_x     = pen_x;
            g.pixel_y    = base_y + POS_W'(r) + 16'd1;
            g.pixel_bits = absent ? '0 : (font_mem[cp * ROWS + r] & COL_MASK);
            g.back_out   = back_reg;
            g.fore_out   = fore_reg;
            g.missing    = absent;
            g.last       = (r == ROWS - 1);
            row_q.push_back(g);
        end
        pen_x = pen_x + POS_W'(COLS + 1);
    endtask

    task automatic decode_word(input logic [1:0] cmd, input logic [S_DATA_W-1:0] d);
        logic [7:0] b;
        int         code;
        int         row;
        b    = d[TXT_LSB +: 8];
        code = int'(d[CODE_LSB +: 8]);
        row  = int'(d[ROW_LSB +: 4]);
        case (cmd)
            CMD_LOAD:
            begin
                if (code < GLYPHS && row < ROWS)
                    font_mem[code * ROWS + row] = d[BITS_LSB +: 16];
            end
            CMD_START:
            begin
                pen_x     = d[SX_LSB +: 16];
                base_y    = d[SY_LSB +: 16];
                back_reg  = d[BK_LSB +: 32];
                fore_reg  = d[FG_LSB +: 32];
                cp_accum  = '0;
                cont_left = '0;
            end
            CMD_TEXT:
            begin
                if (cont_left == 2'd0)
                begin
                    if (b <= ONE_BYTE_MAX)
                    begin
                        cp_accum = CP_W'(b);
                    end
                    else if (b <= TWO_BYTE_MAX)
                    begin
                        cp_accum  = CP_W'(b & LEAD2_MASK);
                        cont_left = 2'd1;
                    end
                    else if (b <= THREE_BYTE_MAX)
                    begin
                        cp_accum  = CP_W'(b & LEAD3_MASK);
                        cont_left = 2'd2;
                    end
                    else
                    begin
                        cp_accum  = CP_W'(b & LEAD4_MASK);
                        cont_left = 2'd3;
                    end
                end
                else
                begin
                    cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                end
                if (cont_left == 2'd0)
                    render_glyph(cp_accum);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_word(input stim_t s);
        int         gap;
        int         k;
        int         base;
        glyph_row_t g;
        k = $urandom_range(0, 9);
        if (hold_req && !hold_done)
            gap = 0;
        else if (k < 6)
            gap = 0;
        else if (k < 9)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s.data;
        s_axis_tuser  <= s.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        base = row_q.size();
        decode_word(s.cmd, s.data);
        if (s.typed)
        begin
            while (row_q.size() > base)
                void'(row_q.pop_back());
            for (int r = 0; r < ROWS; r++)
            begin
                g.cell_x     = s.x0;
                g.pixel_y    = s.y0 + POS_W'(r);
                g.pixel_bits = '0;
                g.back_out   = s.back;
                g.fore_out   = s.fore;
                g.missing    = s.missing;
                g.last       = (r == ROWS - 1);
                row_q.push_back(g);
            end
        end
        if (s.cmd != CMD_UNUSED)
            words_sent++;
    endtask

    task automatic send_code_point(input logic [CP_W-1:0] cp, input int len);
        case (len)
            1:
            begin
                send_word(mk_text({1'b0, cp[6:0]}));
            end
            2:
            begin
                send_word(mk_text({3'b110, cp[10:6]}));
                send_word(mk_text({2'b10, cp[5:0]}));
            end
            3:
            begin
                send_word(mk_text({4'b1110, cp[15:12]}));
                send_word(mk_text({2'b10, cp[11:6]}));
                send_word(mk_text({2'b10, cp[5:0]}));
            end
            default:
            begin
                send_word(mk_text({5'b11110, cp[20:18]}));
                send_word(mk_text({2'b10, cp[17:12]}));
                send_word(mk_text({2'b10, cp[11:6]}));
                send_word(mk_text({2'b10, cp[5:0]}));
            end
        endcase
    endtask

    // output checker
    always @(posedge clk)
    begin : row_check
        glyph_row_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (row_q.size() == 0)
            begin
                $error("unexpected output word: tdata %h tuser %b tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fails++;
            end
            else
            begin
                want = row_q.pop_front();
                if (m_axis_tdata[15:0] !== want.cell_x)
                begin
                    $error("cell_x: expected %h, got %h", want.cell_x, m_axis_tdata[15:0]);
                    fails++;
                end
                if (m_axis_tdata[31:16] !== want.pixel_y)
                begin
                    $error("pixel_y: expected %h, got %h", want.pixel_y, m_axis_tdata[31:16]);
                    fails++;
                end
                if (m_axis_tdata[47:32] !== want.pixel_bits)
                begin
                    $error("pixel_bits: expected %h, got %h",
                           want.pixel_bits, m_axis_tdata[47:32]);
                    fails++;
                end
                if (m_axis_tdata[79:48] !== want.back_out)
                begin
                    $error("back_out: expected %h, got %h", want.back_out, m_axis_tdata[79:48]);
                    fails++;
                end
                if (m_axis_tdata[111:80] !== want.fore_out)
                begin
                    $error("fore_out: expected %h, got %h", want.fore_out, m_axis_tdata[111:80]);
                    fails++;
                end
                if (m_axis_tuser !== want.missing)
                begin
                    $error("glyph_missing: expected %b, got %b", want.missing, m_axis_tuser);
                    fails++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_row: expected %b, got %b", want.last, m_axis_tlast);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver
    initial
    begin : receiver
        int mode;
        int n;
        m_axis_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                mode = $urandom_range(0, 9);
                if (mode < 4)
                begin
                    n = $urandom_range(1, 40);
                    repeat (n)
                    begin
                        m_axis_tready <= 1'b1;
                        @(posedge clk);
                    end
                end
                else if (mode < 8)
                begin
                    n = $urandom_range(1, 30);
                    repeat (n)
                    begin
                        m_axis_tready <= 1'($urandom_range(0, 1));
                        @(posedge clk);
                    end
                end
                else
                begin
                    n = (mode == 8) ? $urandom_range(1, 4) : $urandom_range(20, 60);
                    repeat (n)
                    begin
                        m_axis_tready <= 1'b0;
                        @(posedge clk);
                    end
                end
            end
        end
    end

    // sender and sequence
    initial
    begin : sender
        stim_t      dir_tab [$];
        int         k;
        int         cls;
        logic [7:0] lead;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        words_sent    = 0;
        hold_req      = 1'b0;
        foreach (font_mem[i])
            font_mem[i] = '0;
        cp_accum  = '0;
        cont_left = '0;
        pen_x     = '0;
        base_y    = '0;
        back_reg  = '0;
        fore_reg  = '0;

        dir_tab.push_back(with_blank(mk_text(8'h00), 16'd0, 16'd1, 32'd0, 32'd0, 1'b0));
        dir_tab.push_back(mk_load(8'h41, 4'd0, 16'hFFFF));
        dir_tab.push_back(mk_load(8'h41, 4'd15, 16'h8001));
        dir_tab.push_back(mk_load(8'hFF, 4'd7, 16'hA5C3));
        dir_tab.push_back(mk_load(8'h00, 4'd3, 16'h7E7E));
        dir_tab.push_back(mk_text(8'h00));
        dir_tab.push_back(mk_start(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000));
        dir_tab.push_back(mk_text(8'h41));
        dir_tab.push_back(mk_unused());
        dir_tab.push_back(mk_text(8'hC3));
        dir_tab.push_back(mk_text(8'hBF));
        dir_tab.push_back(mk_start(16'h0000, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF));
        dir_tab.push_back(mk_text(8'hE2));
        dir_tab.push_back(mk_text(8'h82));
        dir_tab.push_back(with_blank(mk_text(8'hAC), 16'd0, 16'd1, 32'h0000_0000,
                                     32'hFFFF_FFFF, 1'b1));
        // start drops the partial sequence
        dir_tab.push_back(mk_text(8'hF0));
        dir_tab.push_back(mk_text(8'h9F));
        dir_tab.push_back(mk_start(16'd100, 16'd200, 32'h1234_5678, 32'h9ABC_DEF0));
        dir_tab.push_back(mk_text(8'h7F));
        dir_tab.push_back(mk_text(8'hF7));
        dir_tab.push_back(mk_text(8'hBF));
        dir_tab.push_back(mk_text(8'hBF));
        dir_tab.push_back(with_blank(mk_text(8'hBF), 16'd109, 16'd201, 32'h1234_5678,
                                     32'h9ABC_DEF0, 1'b1));
        dir_tab.push_back(mk_text(8'hDF));
        dir_tab.push_back(mk_text(8'hFF));
        dir_tab.push_back(mk_text(8'h80));
        dir_tab.push_back(mk_text(8'h41));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_word(dir_tab[i]);

        words_sent = 0;
        while (words_sent < RAND_WORDS)
        begin
            if (words_sent >= 40 && !hold_req)
                hold_req = 1'b1;
            k = $urandom_range(0, 99);
            if (k < 25)
            begin
                send_word(mk_load($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                       : 8'(8'h40 + $urandom_range(0, 3)),
                                  4'($urandom_range(0, 15)), 16'($urandom)));
            end
            else if (k < 30)
            begin
                send_word(mk_start($urandom_range(0, 3) == 0
                                       ? 16'($urandom_range(16'hFFF0, 16'hFFFF))
                                       : 16'($urandom),
                                   16'($urandom), 32'($urandom), 32'($urandom)));
            end
            else if (k < 33)
            begin
                send_word(mk_unused());
            end
            else if (k < 38)
            begin
                send_word(mk_text(8'($urandom_range(0, 255))));
            end
            else if (k < 41)
            begin
                // broken sequence cut short by a start
                lead = 8'($urandom_range(8'hC0, 8'hFF));
                send_word(mk_text(lead));
                if (lead >= 8'hE0)
                    send_word(mk_text(8'($urandom_range(8'h80, 8'hBF))));
                send_word(mk_start(16'($urandom), 16'($urandom), 32'($urandom),
                                   32'($urandom)));
            end
            else
            begin
                cls = $urandom_range(0, 19);
                if (cls < 12)
                    send_code_point($urandom_range(0, 1) ? CP_W'($urandom_range(8'h40, 8'h43))
                                                         : CP_W'($urandom_range(0, 127)), 1);
                else if (cls < 17)
                    send_code_point($urandom_range(0, 2) != 0
                                        ? CP_W'($urandom_range(8'h80, 8'hFF))
                                        : CP_W'($urandom_range(0, 11'h7FF)), 2);
                else if (cls < 19)
                    send_code_point(CP_W'($urandom_range(0, 16'hFFFF)), 3);
                else
                    send_code_point(CP_W'($urandom), 4);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (row_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fails == 0 && row_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
